FILE: hdl/ccv_pkg.sv
// ----------------------------------------------------------------------------
// ccv_pkg
// Types, piece codes and keyword tables shared by the command validator.
// ----------------------------------------------------------------------------
package ccv_pkg;

   localparam int TEXT_LENGTH_BITS_DEF = 16;

   localparam logic [3:0] PC_KEY  = 4'd0;
   localparam logic [3:0] PC_SEQ  = 4'd1;
   localparam logic [3:0] PC_ROW  = 4'd2;
   localparam logic [3:0] PC_COL  = 4'd3;
   localparam logic [3:0] PC_DIR  = 4'd4;
   localparam logic [3:0] PC_TEXT = 4'd5;
   localparam logic [3:0] PC_END  = 4'd6;
   localparam logic [3:0] PC_SAT  = 4'd15;
   localparam logic [3:0] PC_READ_COUNT  = 4'd6;
   localparam logic [3:0] PC_WRITE_COUNT = 4'd7;

   localparam logic [2:0] POS_SAT = 3'd7;
   localparam logic [2:0] LEN_READ  = 3'd4;
   localparam logic [2:0] LEN_WRITE = 3'd5;
   localparam logic [2:0] LEN_DIR   = 3'd2;
   localparam logic [2:0] LEN_END   = 3'd3;

   localparam int FLAG_READ  = 0;
   localparam int FLAG_WRITE = 1;
   localparam int FLAG_END   = 2;

   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        valid_res;
      logic        is_write;
      logic [63:0] sequence_number;
      logic [31:0] row_coord;
      logic [31:0] col_coord;
      logic [1:0]  direction;
      logic [15:0] text_length;
   } rsp_payload_type;

   typedef struct packed {
      logic        nonempty;
      logic [2:0]  kw_pos;
      logic [3:0]  kw_flags;
      logic [63:0] acc;
      logic        num_err;
   } piece_type;

   typedef struct packed {
      logic [3:0]  piece_count;
      logic        empty_seen;
      logic        first_read;
      logic        first_write;
      logic        field_err;
      logic [63:0] seq;
      logic [31:0] row;
      logic [31:0] col;
      logic [1:0]  dir;
      logic        sixth_end;
   } msg_type;

   localparam piece_type PIECE_CLEAR = '{
      nonempty: 1'b0, kw_pos: 3'd0, kw_flags: 4'hF, acc: 64'd0, num_err: 1'b0
   };

   localparam msg_type MSG_CLEAR = '{
      piece_count: 4'd0, empty_seen: 1'b0, first_read: 1'b0, first_write: 1'b0,
      field_err: 1'b0, seq: 64'd0, row: 32'd0, col: 32'd0, dir: 2'd0,
      sixth_end: 1'b0
   };

   // Out-of-range positions return the NUL code, which never matches a taken byte.
   function automatic logic [7:0] read_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = "R";
         3'd1:    ch = "E";
         3'd2:    ch = "A";
         3'd3:    ch = "D";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] write_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = "W";
         3'd1:    ch = "R";
         3'd2:    ch = "I";
         3'd3:    ch = "T";
         3'd4:    ch = "E";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] end_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = "E";
         3'd1:    ch = "N";
         3'd2:    ch = "D";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] dir_char(input logic [1:0] idx, input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = idx[0] ? "-" : "+";
         3'd1:    ch = idx[1] ? "Y" : "X";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

FILE: hdl/csv_command_validator.sv
// ----------------------------------------------------------------------------
// csv_command_validator
// Validates comma separated READ and WRITE command messages byte by byte.
// ----------------------------------------------------------------------------
// The request channel carries one message byte per beat with a last flag.
// Every beat is folded into the message state in the cycle it is accepted,
// so the block takes one byte per cycle while the request side is not stalled,
// with no gaps between messages. The beat with the last flag set produces one
// response beat, loaded into the response register at that edge and shown in the
// next cycle; all other beats produce none. The message state returns to its cleared value after
// each response. The request side stalls only while a response is held and
// the receiver stalls it; otherwise a new byte is accepted even while the
// response register drains. Reset clears the message state and empties the
// response register.
// ----------------------------------------------------------------------------
module csv_command_validator #(
   parameter int TEXT_LENGTH_BITS = ccv_pkg::TEXT_LENGTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ccv_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ccv_pkg::rsp_payload_type rsp_data
);
   import ccv_pkg::*;

   piece_type piece_ff, piece_in, piece_taken, piece_to_close;
   msg_type   msg_ff, msg_in, msg_closed, msg_final;
   logic [TEXT_LENGTH_BITS-1:0] text_ff, text_in, text_step;
   logic [TEXT_LENGTH_BITS+15:0] text_wide;
   logic stopped_ff, stopped_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic accept, active, is_comma, is_nul, take_byte, do_close;
   logic checks_ok, ok, wr;
   piece_type piece_step;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign active    = !stopped_ff;
   assign is_nul    = (req_data.byte_in == CH_NUL);
   assign is_comma  = (req_data.byte_in == CH_COMMA);
   assign take_byte = active && !is_nul && !is_comma;

   ccv_take u_take (
      .piece       (piece_ff),
      .piece_count (msg_ff.piece_count),
      .byte_in     (req_data.byte_in),
      .piece_next  (piece_taken)
   );

   assign piece_step     = take_byte ? piece_taken : piece_ff;
   assign piece_to_close = (active && is_comma) ? piece_ff : piece_step;
   assign do_close       = (active && is_comma) || (req_data.last_byte && piece_step.nonempty);

   ccv_close u_close (
      .piece    (piece_to_close),
      .msg      (msg_ff),
      .msg_next (msg_closed)
   );

   assign msg_final = do_close ? msg_closed : msg_ff;

   assign text_step = (take_byte && (msg_ff.piece_count == PC_TEXT) && (text_ff != '1))
                    ? text_ff + TEXT_LENGTH_BITS'(1) : text_ff;
   assign text_wide = {16'd0, text_step};

   assign checks_ok = !msg_final.empty_seen && !msg_final.field_err;
   assign wr = checks_ok && (msg_final.piece_count == PC_WRITE_COUNT) && msg_final.first_write;
   assign ok = wr || (checks_ok && (msg_final.piece_count == PC_READ_COUNT)
                      && msg_final.first_read && msg_final.sixth_end);

   always_comb begin
      rsp_data_in.valid_res       = ok;
      rsp_data_in.is_write        = wr;
      rsp_data_in.sequence_number = ok ? msg_final.seq : 64'd0;
      rsp_data_in.row_coord       = ok ? msg_final.row : 32'd0;
      rsp_data_in.col_coord       = ok ? msg_final.col : 32'd0;
      rsp_data_in.direction       = ok ? msg_final.dir : 2'd0;
      rsp_data_in.text_length     = wr ? text_wide[15:0] : 16'd0;
   end

   always_comb begin
      piece_in     = piece_ff;
      msg_in       = msg_ff;
      text_in      = text_ff;
      stopped_in   = stopped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         if (req_data.last_byte) begin
            piece_in     = PIECE_CLEAR;
            msg_in       = MSG_CLEAR;
            text_in      = '0;
            stopped_in   = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            piece_in   = (active && is_comma) ? PIECE_CLEAR : piece_step;
            msg_in     = msg_final;
            text_in    = text_step;
            stopped_in = stopped_ff || is_nul;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_ff     <= PIECE_CLEAR;
         msg_ff       <= MSG_CLEAR;
         text_ff      <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         piece_ff     <= piece_in;
         msg_ff       <= msg_in;
         text_ff      <= text_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/ccv_take.sv
// ----------------------------------------------------------------------------
// ccv_take
// Folds one content byte into the open piece: keyword match and decimal step.
// ----------------------------------------------------------------------------
module ccv_take (
   input  ccv_pkg::piece_type piece,
   input  logic [3:0]         piece_count,
   input  logic [7:0]         byte_in,
   output ccv_pkg::piece_type piece_next
);
   import ccv_pkg::*;

   logic        is_digit;
   logic [3:0]  digit;
   logic [67:0] scaled;

   assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign digit    = 4'(byte_in - CH_ZERO);
   assign scaled   = {1'b0, piece.acc, 3'b000} + {3'b000, piece.acc, 1'b0}
                   + {64'd0, digit};

   always_comb begin
      piece_next          = piece;
      piece_next.nonempty = 1'b1;
      unique case (piece_count)
         PC_KEY: begin
            if (byte_in != read_char(piece.kw_pos)) piece_next.kw_flags[FLAG_READ] = 1'b0;
            if (byte_in != write_char(piece.kw_pos)) piece_next.kw_flags[FLAG_WRITE] = 1'b0;
         end
         PC_SEQ, PC_ROW, PC_COL: begin
            if (!is_digit || (scaled[67:64] != 4'd0)) begin
               piece_next.num_err = 1'b1;
            end else begin
               piece_next.acc = scaled[63:0];
            end
         end
         PC_DIR: begin
            for (int i = 0; i < 4; i++) begin
               if (byte_in != dir_char(2'(i), piece.kw_pos)) piece_next.kw_flags[i] = 1'b0;
            end
         end
         PC_TEXT, PC_END: begin
            if (byte_in != end_char(piece.kw_pos)) piece_next.kw_flags[FLAG_END] = 1'b0;
         end
         default: begin
         end
      endcase
      if (piece.kw_pos != POS_SAT) piece_next.kw_pos = piece.kw_pos + 3'd1;
   end

endmodule

FILE: hdl/ccv_close.sv
// ----------------------------------------------------------------------------
// ccv_close
// Checks a finished piece against its position and updates the message record.
// ----------------------------------------------------------------------------
module ccv_close (
   input  ccv_pkg::piece_type piece,
   input  ccv_pkg::msg_type   msg,
   output ccv_pkg::msg_type   msg_next
);
   import ccv_pkg::*;

   logic end_hit;

   assign end_hit = piece.kw_flags[FLAG_END] && (piece.kw_pos == LEN_END);

   always_comb begin
      msg_next = msg;
      if (!piece.nonempty) msg_next.empty_seen = 1'b1;
      unique case (msg.piece_count)
         PC_KEY: begin
            msg_next.first_read  = piece.kw_flags[FLAG_READ] && (piece.kw_pos == LEN_READ);
            msg_next.first_write = piece.kw_flags[FLAG_WRITE] && (piece.kw_pos == LEN_WRITE);
         end
         PC_SEQ: begin
            if (piece.num_err || (piece.acc == '0) || (piece.acc == '1)) begin
               msg_next.field_err = 1'b1;
            end else begin
               msg_next.seq = piece.acc;
            end
         end
         PC_ROW, PC_COL: begin
            if (piece.num_err || (piece.acc[63:32] != '0) || (piece.acc[31:0] == '1)) begin
               msg_next.field_err = 1'b1;
            end else if (msg.piece_count == PC_ROW) begin
               msg_next.row = piece.acc[31:0];
            end else begin
               msg_next.col = piece.acc[31:0];
            end
         end
         PC_DIR: begin
            if ((piece.kw_pos != LEN_DIR) || (piece.kw_flags == 4'd0)) begin
               msg_next.field_err = 1'b1;
            end else begin
               priority if (piece.kw_flags[0]) msg_next.dir = 2'd0;
               else if (piece.kw_flags[1])     msg_next.dir = 2'd1;
               else if (piece.kw_flags[2])     msg_next.dir = 2'd2;
               else                            msg_next.dir = 2'd3;
            end
         end
         PC_TEXT: begin
            msg_next.sixth_end = end_hit;
         end
         PC_END: begin
            if (!end_hit) msg_next.field_err = 1'b1;
         end
         default: begin
         end
      endcase
      if (msg.piece_count != PC_SAT) msg_next.piece_count = msg.piece_count + 4'd1;
   end

endmodule

FILE: tb/tb_csv_command_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_command_validator
// Self-checking testbench for the comma separated command validator. Messages
// are sent one byte per beat: a directed set covering field limits, trailing
// commas, early NUL, bad keywords and non-printable text bytes, then random
// well-formed, damaged and noise messages under varying idle patterns on both
// channels. A scoreboard predicts each verdict from the accepted bytes and
// compares it field by field with the response beats.
// ----------------------------------------------------------------------------
module tb_csv_command_validator;
   import ccv_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 60;

   class command_checker;
      bit [3:0]  field_count;
      bit        field_has_chars;
      bit        empty_field_seen;
      bit [2:0]  match_pos;
      bit [3:0]  match_live;
      bit [63:0] digits_value;
      bit        digits_bad;
      bit        lead_read;
      bit        lead_write;
      bit        bad_field;
      bit [63:0] seq_seen;
      bit [31:0] row_seen;
      bit [31:0] col_seen;
      bit [1:0]  dir_seen;
      bit        sixth_end;
      bit [15:0] text_bytes;
      bit        after_nul;
      string     dir_words[4] = '{"+X", "-X", "+Y", "-Y"};
      rsp_payload_type pending_verdicts[$];
      int        mismatches;

      function new();
         mismatches = 0;
         clear_message();
      endfunction

      function void clear_field();
         field_has_chars = 1'b0;
         match_pos       = '0;
         match_live      = 4'hF;
         digits_value    = '0;
         digits_bad      = 1'b0;
      endfunction

      function void clear_message();
         field_count      = '0;
         empty_field_seen = 1'b0;
         lead_read        = 1'b0;
         lead_write       = 1'b0;
         bad_field        = 1'b0;
         seq_seen         = '0;
         row_seen         = '0;
         col_seen         = '0;
         dir_seen         = '0;
         sixth_end        = 1'b0;
         text_bytes       = '0;
         after_nul        = 1'b0;
         clear_field();
      endfunction

      function void match_keyword(int flag, string word, bit [7:0] ch);
         if (match_pos >= word.len() || word[match_pos] != ch) match_live[flag] = 1'b0;
      endfunction

      function void add_digit(bit [7:0] ch);
         bit [63:0] d;
         if (ch < CH_ZERO || ch > CH_NINE) begin
            digits_bad = 1'b1;
            return;
         end
         d = ch - CH_ZERO;
         if (digits_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) begin
            digits_bad = 1'b1;
            return;
         end
         digits_value = digits_value * 10 + d;
      endfunction

      function void absorb_char(bit [7:0] ch);
         field_has_chars = 1'b1;
         case (field_count)
            PC_KEY: begin
               match_keyword(FLAG_READ, "READ", ch);
               match_keyword(FLAG_WRITE, "WRITE", ch);
            end
            PC_SEQ, PC_ROW, PC_COL: add_digit(ch);
            PC_DIR: for (int i = 0; i < 4; i++) match_keyword(i, dir_words[i], ch);
            PC_TEXT: begin
               match_keyword(FLAG_END, "END", ch);
               if (text_bytes != 16'hFFFF) text_bytes++;
            end
            PC_END: match_keyword(FLAG_END, "END", ch);
            default: ;
         endcase
         if (match_pos != POS_SAT) match_pos++;
      endfunction

      function bit end_seen();
         return match_live[FLAG_END] && match_pos == LEN_END;
      endfunction

      function void close_field();
         bit found;
         found = 1'b0;
         if (!field_has_chars) empty_field_seen = 1'b1;
         case (field_count)
            PC_KEY: begin
               lead_read  = match_live[FLAG_READ] && match_pos == LEN_READ;
               lead_write = match_live[FLAG_WRITE] && match_pos == LEN_WRITE;
            end
            PC_SEQ: begin
               if (digits_bad || digits_value == 0 || digits_value == '1) bad_field = 1'b1;
               else seq_seen = digits_value;
            end
            PC_ROW, PC_COL: begin
               if (digits_bad || digits_value >= 64'hFFFF_FFFF) bad_field = 1'b1;
               else if (field_count == PC_ROW) row_seen = digits_value[31:0];
               else col_seen = digits_value[31:0];
            end
            PC_DIR: begin
               if (match_pos == LEN_DIR) begin
                  for (int i = 0; i < 4; i++) begin
                     if (!found && match_live[i]) begin
                        dir_seen = 2'(i);
                        found    = 1'b1;
                     end
                  end
               end
               if (!found) bad_field = 1'b1;
            end
            PC_TEXT: sixth_end = end_seen();
            PC_END: begin
               if (!end_seen()) bad_field = 1'b1;
            end
            default: ;
         endcase
         if (field_count != PC_SAT) field_count++;
         clear_field();
      endfunction

      function void note_byte(req_payload_type beat);
         rsp_payload_type verdict;
         bit ok;
         bit wr;
         if (!after_nul) begin
            if (beat.byte_in == CH_NUL) after_nul = 1'b1;
            else if (beat.byte_in == CH_COMMA) close_field();
            else absorb_char(beat.byte_in);
         end
         if (!beat.last_byte) return;
         if (field_has_chars) close_field();
         ok = 1'b0;
         wr = 1'b0;
         if (!empty_field_seen && !bad_field) begin
            if (field_count == PC_READ_COUNT && lead_read && sixth_end) ok = 1'b1;
            if (field_count == PC_WRITE_COUNT && lead_write) begin
               ok = 1'b1;
               wr = 1'b1;
            end
         end
         verdict.valid_res       = ok;
         verdict.is_write        = wr;
         verdict.sequence_number = ok ? seq_seen : '0;
         verdict.row_coord       = ok ? row_seen : '0;
         verdict.col_coord       = ok ? col_seen : '0;
         verdict.direction       = ok ? dir_seen : '0;
         verdict.text_length     = wr ? text_bytes : '0;
         pending_verdicts.insert(pending_verdicts.size(), verdict);
         clear_message();
      endfunction

      task report_mismatch(string what, logic [63:0] got_val, logic [63:0] want_val);
         $display("mismatch at %0t in %s: got %0h, expected %0h", $time, what, got_val,
                  want_val);
         mismatches++;
      endtask

      task check_verdict(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("response beat with none pending", got.valid_res, 1'b0);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.valid_res !== want.valid_res)
            report_mismatch("valid_res", got.valid_res, want.valid_res);
         if (got.is_write !== want.is_write)
            report_mismatch("is_write", got.is_write, want.is_write);
         if (got.sequence_number !== want.sequence_number)
            report_mismatch("sequence_number", got.sequence_number, want.sequence_number);
         if (got.row_coord !== want.row_coord)
            report_mismatch("row_coord", got.row_coord, want.row_coord);
         if (got.col_coord !== want.col_coord)
            report_mismatch("col_coord", got.col_coord, want.col_coord);
         if (got.direction !== want.direction)
            report_mismatch("direction", got.direction, want.direction);
         if (got.text_length !== want.text_length)
            report_mismatch("text_length", got.text_length, want.text_length);
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   command_checker board;
   logic [7:0]     msg_bytes[$];
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             hold_req = 0;
   int             hold_done = 0;
   int             beats_sent = 0;
   int             messages_sent = 0;
   int             cycle_count = 0;

   csv_command_validator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_verdict(rsp_data);
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            hold_done = hold_req;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic void append_byte(logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_in: b, last_byte: fin};
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_byte(req_data);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_message();
      if (msg_bytes.size() == 0) append_byte(CH_COMMA);
      for (int i = 0; i < msg_bytes.size(); i++) send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
      messages_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending_verdicts.size() != 0);
   endtask

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   task automatic send_str(string s);
      put_str(s);
      send_message();
   endtask

   function automatic string decimal_text(bit [63:0] v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) s = {"0", s};
      return s;
   endfunction

   function automatic string seq_text();
      bit [63:0] v;
      v = {$urandom, $urandom} >> $urandom_range(63);
      case ($urandom_range(15))
         0: v = 64'd1;
         1: v = 64'hFFFF_FFFF_FFFF_FFFE;
         2: v = '1;
         3: return "18446744073709551616";
         4: v = '0;
         default: ;
      endcase
      return decimal_text(v);
   endfunction

   function automatic string coord_text();
      bit [31:0] v;
      v = $urandom >> $urandom_range(31);
      case ($urandom_range(15))
         0: v = '0;
         1: v = 32'hFFFF_FFFE;
         2: v = '1;
         3: return "4294967296";
         4: return "7z";
         default: ;
      endcase
      return decimal_text({32'd0, v});
   endfunction

   function automatic string dir_text();
      string names[4];
      names = '{"+X", "-X", "+Y", "-Y"};
      case ($urandom_range(19))
         0: return "+Z";
         1: return "X";
         2: return "+XY";
         default: return names[$urandom_range(3)];
      endcase
   endfunction

   function automatic void put_text();
      logic [7:0] b;
      int n;
      case ($urandom_range(9))
         0: n = 0;
         1: n = $urandom_range(20, 60);
         2: begin
            put_str("END");
            return;
         end
         default: n = $urandom_range(1, 8);
      endcase
      repeat (n) begin
         b = 8'($urandom_range(1, 255));
         if (b == CH_COMMA) b = ".";
         append_byte(b);
      end
   endfunction

   function automatic void build_command(bit head_write, bit with_text);
      put_str(head_write ? "WRITE," : "READ,");
      put_str({seq_text(), ",", coord_text(), ",", coord_text(), ",", dir_text(), ","});
      if (with_text) begin
         put_text();
         append_byte(CH_COMMA);
      end
      put_str("END");
      case ($urandom_range(9))
         0: append_byte(CH_COMMA);
         1: put_str(",,");
         2: begin
            append_byte(CH_NUL);
            repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(255)));
         end
         default: ;
      endcase
   endfunction

   function automatic void mutate_message();
      int i;
      if (msg_bytes.size() == 0) return;
      i = $urandom_range(msg_bytes.size() - 1);
      case ($urandom_range(4))
         0: msg_bytes[i] = 8'($urandom_range(255));
         1: msg_bytes.delete(i);
         2: msg_bytes.insert(i, CH_COMMA);
         3: msg_bytes.insert(i, CH_NUL);
         default: msg_bytes.insert(i, 8'($urandom_range(255)));
      endcase
   endfunction

   task automatic send_random_message();
      int pick;
      bit wr;
      pick = $urandom_range(99);
      wr   = 1'($urandom_range(1));
      if (pick < 65) begin
         build_command(wr, wr);
      end else if (pick < 85) begin
         build_command(wr, 1'($urandom_range(1)));
         repeat ($urandom_range(1, 2)) mutate_message();
      end else begin
         repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(255)));
      end
      send_message();
   endtask

   task automatic run_phase(int s_pct, int r_pct, bit with_hold, bit with_pause);
      int start_beats;
      int start_msgs;
      start_beats  = beats_sent;
      start_msgs   = messages_sent;
      req_idle_pct = s_pct;
      rsp_idle_pct = r_pct;
      if (with_hold) hold_req++;
      while (beats_sent - start_beats < PHASE_BEATS || messages_sent - start_msgs < 2) begin
         if (with_pause && messages_sent - start_msgs == 1) wait_drained();
         send_random_message();
      end
      wait_drained();
   endtask

   task automatic run_directed();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      send_str("READ,1,0,0,+X,END");
      send_str("WRITE,18446744073709551614,4294967294,4294967294,-Y,a,END");
      send_str("READ,7,12,34,-X,END,");
      send_str("READ,7,12,34,+Y,END,,");
      send_str("READ,0,1,1,+X,END");
      send_str("READ,18446744073709551615,1,1,+X,END");
      send_str("READ,99999999999999999999,1,1,+X,END");
      send_str("WRITE,3,4294967295,1,-X,hello,END");
      send_str("WRITE,3,1,12a,-X,hello,END");
      send_str("READ,000000000000000000000000000042,0007,00,-Y,END");
      send_str("READ,5,6,7,+Z,END");
      put_str("READ,1,2,3,+X,END");
      append_byte(CH_NUL);
      put_str("zz,,9");
      send_message();
      append_byte(CH_NUL);
      send_message();
      send_str(",");
      repeat (20) put_str("1,");
      send_str("END");
      send_str("READREADREAD,1,2,3,+X,END");
      send_str("WRITE,1,2,3,+X,,END");
      send_str("READ,1,2,3,+X,ENDX");
      send_str("WRITE,1,2,3,+X,text,ENDE");
      send_str("WRITE,1,2,3,-Y,END");
      send_str(",1,2,3,+X,END");
      put_str("WRITE,5,6,7,-X,");
      append_byte(8'hFF);
      append_byte(8'h80);
      append_byte(8'h01);
      send_str(",END");
      wait_drained();
   endtask

   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_phase(31, 45, 1'b1, 1'b0);
      run_phase(45, 31, 1'b0, 1'b1);
      run_phase(0, 0, 1'b0, 1'b0);
      repeat (10) @(negedge clock);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
